[sv/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, constants and helpers for the spatial pattern prefetcher.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int ADDR_W   = 48;
  localparam int STAMP_W  = 32;
  localparam int OFF_W    = 6;
  localparam int REGION_W = 36;
  localparam int MAP_W    = 64;

  localparam logic OP_ACCESS     = 1'b0;
  localparam logic OP_REGION_END = 1'b1;

  typedef struct packed {
    logic               op;
    logic [ADDR_W-1:0]  pc;
    logic [ADDR_W-1:0]  addr;
    logic [STAMP_W-1:0] now;
  } spp_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pc;
    logic [OFF_W-1:0]   offset;
    logic [STAMP_W-1:0] stamp;
  } spp_filt_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pc;
    logic [REGION_W-1:0] region;
    logic [STAMP_W-1:0]  stamp;
    logic [MAP_W-1:0]    bitmap;
  } spp_acc_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pc;
    logic [REGION_W-1:0] region;
    logic [STAMP_W-1:0]  stamp;
    logic [MAP_W-1:0]    bitmap;
    logic [OFF_W-1:0]    pointer;
  } spp_hist_t;

  // Lowest set bit of a map; the top bit of the result flags that one was found.
  function automatic logic [OFF_W:0] first_set(input logic [MAP_W-1:0] m);
    logic [OFF_W:0] r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = {1'b1, OFF_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

[sv/spp_front.sv]
// ----------------------------------------------------------------------------
// spp_front
// Accepts items from the command port and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module spp_front
  import spp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                op,
  input  logic [ADDR_W-1:0]   instr_addr,
  input  logic [ADDR_W-1:0]   mem_addr,
  input  logic [STAMP_W-1:0]  timestamp,
  output logic                busy,
  input  logic                pop,
  output logic                avail,
  output spp_item_t           item
);

  spp_item_t  q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign busy  = (count == 2'd2);
  assign push  = start && !busy;
  assign avail = (count != 2'd0);
  assign item  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= '{op: (op == OP_REGION_END) ? OP_REGION_END : OP_ACCESS,
                   pc: instr_addr, addr: mem_addr, now: timestamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
      (push && !pop && count == 2'd1) |=> busy)
    else $error("queue failed to report full");

endmodule

[sv/spp_back.sv]
// ----------------------------------------------------------------------------
// spp_back
// Sequencer that walks the history, accumulation and filter tables one entry
// at a time, issues prefetches and trains the tables.
// ----------------------------------------------------------------------------
module spp_back
  import spp_pkg::*;
#(
  parameter int TRAIN_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  spp_item_t         item,
  output logic              pop,
  output logic              done,
  output logic              pf_valid,
  output logic [ADDR_W-1:0] pf_addr
);

  localparam int TIW = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
  localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_H_RD, S_H_CHK, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK,
    S_V_RD, S_V_CHK, S_E_RD, S_E_CHK, S_X_RD, S_X_CHK
  } state_t;

  state_t              state, state_next;
  spp_item_t           cur, cur_next;
  logic [TIW-1:0]      tidx, tidx_next, tuse, tuse_next;
  logic [HIW-1:0]      hidx, hidx_next, huse, huse_next;
  logic [STAMP_W-1:0]  best, best_next;
  logic [TIW-1:0]      fsel, fsel_next, esel, esel_next;
  logic [OFF_W-1:0]    foff, foff_next;
  logic [REGION_W-1:0] e_region, e_region_next;
  logic [MAP_W-1:0]    e_bitmap, e_bitmap_next;
  logic [TRAIN_DEPTH-1:0]   fv, fv_next, av, av_next;
  logic [HISTORY_DEPTH-1:0] hv, hv_next;
  logic                done_next, pf_valid_next;
  logic [ADDR_W-1:0]   pf_addr_next;

  spp_filt_t filt_mem [TRAIN_DEPTH];
  spp_acc_t  acc_mem  [TRAIN_DEPTH];
  spp_hist_t hist_mem [HISTORY_DEPTH];
  spp_filt_t f_rd;
  spp_acc_t  a_rd;
  spp_hist_t h_rd;

  logic           f_we, a_we, h_we;
  logic [TIW-1:0] f_wa, a_wa;
  logic [HIW-1:0] h_wa;
  spp_filt_t      f_wd;
  spp_acc_t       a_wd;
  spp_hist_t      h_wd;

  logic [OFF_W-1:0]    off;
  logic [REGION_W-1:0] region;
  logic                t_last, h_last;
  logic [OFF_W:0]      fs;

  assign off    = cur.addr[11:6];
  assign region = cur.addr[ADDR_W-1:12];
  assign t_last = (tidx == TIW'(TRAIN_DEPTH - 1));
  assign h_last = (hidx == HIW'(HISTORY_DEPTH - 1));
  assign fs     = first_set(h_rd.bitmap & ({MAP_W{1'b1}} << h_rd.pointer));

  always_ff @(posedge clk) begin
    f_rd <= filt_mem[tidx];
    a_rd <= acc_mem[tidx];
    h_rd <= hist_mem[hidx];
    if (f_we) begin
      filt_mem[f_wa] <= f_wd;
    end
    if (a_we) begin
      acc_mem[a_wa] <= a_wd;
    end
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    tidx_next     = tidx;
    tuse_next     = tuse;
    hidx_next     = hidx;
    huse_next     = huse;
    best_next     = best;
    fsel_next     = fsel;
    esel_next     = esel;
    foff_next     = foff;
    e_region_next = e_region;
    e_bitmap_next = e_bitmap;
    fv_next       = fv;
    av_next       = av;
    hv_next       = hv;
    done_next     = 1'b0;
    pf_valid_next = 1'b0;
    pf_addr_next  = '0;
    pop  = 1'b0;
    f_we = 1'b0;
    a_we = 1'b0;
    h_we = 1'b0;
    f_wa = tidx;
    a_wa = tidx;
    h_wa = hidx;
    f_wd = f_rd;
    a_wd = a_rd;
    h_wd = h_rd;

    unique case (state)
      S_IDLE: begin
        if (avail) begin
          pop        = 1'b1;
          cur_next   = item;
          tidx_next  = '0;
          tuse_next  = '0;
          hidx_next  = '0;
          huse_next  = '0;
          best_next  = item.now;
          state_next = (item.op == OP_REGION_END) ? S_E_RD : S_H_RD;
        end
      end
      S_H_RD: state_next = S_H_CHK;
      S_H_CHK: begin
        if (hv[hidx] && h_rd.pc == cur.pc) begin
          h_we       = 1'b1;
          h_wd.stamp = cur.now;
        end
        if (hv[hidx] && h_rd.pc == cur.pc && fs[OFF_W]) begin
          h_wd.pointer  = fs[OFF_W-1:0] + OFF_W'(1);
          done_next     = 1'b1;
          pf_valid_next = 1'b1;
          pf_addr_next  = {h_rd.region, fs[OFF_W-1:0], 6'b0};
          state_next    = S_IDLE;
        end else if (h_last) begin
          tidx_next  = '0;
          tuse_next  = '0;
          best_next  = cur.now;
          state_next = S_A_RD;
        end else begin
          hidx_next  = hidx + HIW'(1);
          state_next = S_H_RD;
        end
      end
      S_A_RD: state_next = S_A_CHK;
      S_A_CHK: begin
        if (av[tidx] && a_rd.pc == cur.pc) begin
          a_we        = 1'b1;
          a_wd.stamp  = cur.now;
          a_wd.bitmap = a_rd.bitmap | (MAP_W'(1) << off);
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (!av[tidx] || t_last) begin
          tidx_next  = '0;
          tuse_next  = '0;
          best_next  = cur.now;
          state_next = S_F_RD;
        end else begin
          tidx_next  = tidx + TIW'(1);
          state_next = S_A_RD;
        end
      end
      S_F_RD: state_next = S_F_CHK;
      S_F_CHK: begin
        if (fv[tidx] && f_rd.pc == cur.pc) begin
          f_we       = 1'b1;
          f_wd.stamp = cur.now;
          if (off == f_rd.offset) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            fsel_next  = tidx;
            foff_next  = f_rd.offset;
            tidx_next  = '0;
            tuse_next  = '0;
            best_next  = cur.now;
            state_next = S_V_RD;
          end
        end else if (!fv[tidx] || t_last) begin
          f_we = 1'b1;
          if (fv[tidx] && !(f_rd.stamp < best)) begin
            f_wa = tuse;
          end
          f_wd          = '{pc: cur.pc, offset: off, stamp: cur.now};
          fv_next[f_wa] = 1'b1;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          if (f_rd.stamp < best) begin
            best_next = f_rd.stamp;
            tuse_next = tidx;
          end
          tidx_next  = tidx + TIW'(1);
          state_next = S_F_RD;
        end
      end
      S_V_RD: state_next = S_V_CHK;
      S_V_CHK: begin
        if (!av[tidx] || t_last) begin
          a_we = 1'b1;
          if (av[tidx] && !(a_rd.stamp < best)) begin
            a_wa = tuse;
          end
          a_wd = '{pc: cur.pc, region: region, stamp: cur.now,
                   bitmap: (MAP_W'(1) << off) | (MAP_W'(1) << foff)};
          av_next[a_wa] = 1'b1;
          fv_next[fsel] = 1'b0;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          if (a_rd.stamp < best) begin
            best_next = a_rd.stamp;
            tuse_next = tidx;
          end
          tidx_next  = tidx + TIW'(1);
          state_next = S_V_RD;
        end
      end
      S_E_RD: state_next = S_E_CHK;
      S_E_CHK: begin
        if (fv[tidx] && f_rd.pc == cur.pc) begin
          fv_next[tidx] = 1'b0;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else if (av[tidx] && a_rd.pc == cur.pc) begin
          esel_next     = tidx;
          e_region_next = a_rd.region;
          e_bitmap_next = a_rd.bitmap;
          hidx_next     = '0;
          huse_next     = '0;
          best_next     = cur.now;
          state_next    = S_X_RD;
        end else if (t_last) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          tidx_next  = tidx + TIW'(1);
          state_next = S_E_RD;
        end
      end
      S_X_RD: state_next = S_X_CHK;
      S_X_CHK: begin
        if (!hv[hidx] || h_last) begin
          h_we = 1'b1;
          if (hv[hidx] && !(h_rd.stamp < best)) begin
            h_wa = huse;
          end
          h_wd = '{pc: cur.pc, region: e_region, stamp: cur.now,
                   bitmap: e_bitmap, pointer: '0};
          hv_next[h_wa] = 1'b1;
          av_next[esel] = 1'b0;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          if (h_rd.stamp < best) begin
            best_next = h_rd.stamp;
            huse_next = hidx;
          end
          hidx_next  = hidx + HIW'(1);
          state_next = S_X_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fv       <= '0;
      av       <= '0;
      hv       <= '0;
      done     <= 1'b0;
      pf_valid <= 1'b0;
      pf_addr  <= '0;
    end else begin
      state    <= state_next;
      fv       <= fv_next;
      av       <= av_next;
      hv       <= hv_next;
      done     <= done_next;
      pf_valid <= pf_valid_next;
      pf_addr  <= pf_addr_next;
    end
    cur      <= cur_next;
    tidx     <= tidx_next;
    tuse     <= tuse_next;
    hidx     <= hidx_next;
    huse     <= huse_next;
    best     <= best_next;
    fsel     <= fsel_next;
    esel     <= esel_next;
    foff     <= foff_next;
    e_region <= e_region_next;
    e_bitmap <= e_bitmap_next;
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
      !pf_valid |-> pf_addr == '0)
    else $error("prefetch address set without a prefetch");
  a_pf_strobe: assert property (@(posedge clk) disable iff (rst) pf_valid |-> done)
    else $error("prefetch flagged outside a result");
  a_move_src: assert property (@(posedge clk) disable iff (rst)
      state == S_X_CHK |-> av[esel])
    else $error("accumulation entry lost before move to history");

endmodule

[sv/spatial_pattern_prefetcher.sv]
// ----------------------------------------------------------------------------
// spatial_pattern_prefetcher
// PC-keyed spatial prefetcher with filter, accumulation and history tables.
// ----------------------------------------------------------------------------
// An access walks the history table and then the training tables; a region
// end walks the training tables and then the history table.
// One item is worked on at a time, set by the single table-walk sequencer;
// a two-item queue takes new items meanwhile. The receiver cannot stall.
// Reset clears all valid bits; the block is ready at once.
module spatial_pattern_prefetcher
  import spp_pkg::*;
#(
  parameter int TRAIN_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [ADDR_W-1:0]  instr_addr,
  input  logic [ADDR_W-1:0]  mem_addr,
  input  logic [STAMP_W-1:0] timestamp,
  output logic               done,
  output logic               prefetch_valid,
  output logic [ADDR_W-1:0]  prefetch_addr
);

  spp_item_t item;
  logic      avail;
  logic      pop;

  spp_front u_front (
    .clk(clk), .rst(rst), .start(start), .op(op), .instr_addr(instr_addr),
    .mem_addr(mem_addr), .timestamp(timestamp), .busy(busy),
    .pop(pop), .avail(avail), .item(item)
  );

  spp_back #(
    .TRAIN_DEPTH(TRAIN_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .avail(avail), .item(item), .pop(pop),
    .done(done), .pf_valid(prefetch_valid), .pf_addr(prefetch_addr)
  );

endmodule
